// File: rtl/core/fqs_pkg.sv
// shared types and constants for the fifo queue with search
package fqs_pkg;

  localparam int unsigned FqsDepth = 16;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_e;

  // queue update command broadcast to every cell
  typedef struct packed {
    logic                    shift;
    logic                    ins;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

  // search token traveling down the chain
  typedef struct packed {
    logic                    tok;
    logic                    hit;
    logic signed [DataW-1:0] key;
  } srch_t;

  // queue status seen by the controller
  typedef struct packed {
    logic                    head_occ;
    logic                    tail_occ;
    logic signed [DataW-1:0] head_data;
  } q_stat_t;

endpackage

// File: rtl/core/fqs_in_if.sv
// command channel interface
interface fqs_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

// File: rtl/core/fqs_out_if.sv
// result channel interface
interface fqs_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] data_out;
  logic               found;

  modport source (output valid, output status, output data_out, output found, input ready);
  modport sink (input valid, input status, input data_out, input found, output ready);
endinterface

// File: rtl/core/fqs_cell.sv
// one queue cell: stored entry, occupied flag and one search stage
module fqs_cell
  import fqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    prev_occ_i,
  input  logic                    next_occ_i,
  input  logic signed [DataW-1:0] next_data_i,
  input  srch_t                   srch_i,
  output srch_t                   srch_o,
  output logic                    occ_o,
  output logic signed [DataW-1:0] data_o
);

  logic                    occ_q, occ_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic                    data_en;
  logic                    tok_q, hit_q;
  logic signed [DataW-1:0] key_q;

  always_comb begin
    occ_d   = occ_q;
    data_d  = data_q;
    data_en = 1'b0;
    if (ctrl_i.shift) begin
      occ_d   = next_occ_i;
      data_d  = next_data_i;
      data_en = 1'b1;
    end else if (ctrl_i.ins && !occ_q && prev_occ_i) begin
      occ_d   = 1'b1;
      data_d  = ctrl_i.value;
      data_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      tok_q <= srch_i.tok;
      hit_q <= srch_i.hit | (occ_q && (data_q == srch_i.key));
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_en) begin
      data_q <= data_d;
    end
    key_q <= srch_i.key;
  end

  assign srch_o.tok = tok_q;
  assign srch_o.hit = hit_q;
  assign srch_o.key = key_q;
  assign occ_o      = occ_q;
  assign data_o     = data_q;

endmodule

// File: rtl/core/fqs_ctrl.sv
// command decode, search sequencing and result register
module fqs_ctrl
  import fqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic signed [DataW-1:0] value_i,
  input  q_stat_t                 qstat_i,
  input  srch_t                   srch_last_i,
  output cell_ctrl_t              ctrl_o,
  output srch_t                   srch_first_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] data_out_o,
  output logic                    found_o
);

  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 status_q, status_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic                    found_q, found_d;
  logic                    load;
  logic                    accept;
  op_e                     op;

  assign op = op_e'(operation_i);

  always_comb begin
    state_d             = state_q;
    in_ready_o          = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
    accept              = in_valid_i && in_ready_o;
    ctrl_o.shift        = 1'b0;
    ctrl_o.ins          = 1'b0;
    ctrl_o.value        = value_i;
    srch_first_o.tok    = 1'b0;
    srch_first_o.hit    = 1'b0;
    srch_first_o.key    = value_i;
    load                = 1'b0;
    status_d            = STAT_DONE;
    data_d              = '0;
    found_d             = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_INSERT: begin
              load = 1'b1;
              if (qstat_i.tail_occ) begin
                status_d = STAT_FULL;
              end else begin
                ctrl_o.ins = 1'b1;
              end
            end
            OP_REMOVE: begin
              load = 1'b1;
              if (!qstat_i.head_occ) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl_o.shift = 1'b1;
                data_d       = qstat_i.head_data;
              end
            end
            OP_SEARCH: begin
              srch_first_o.tok = 1'b1;
              state_d          = S_SEARCH;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (srch_last_i.tok) begin
          load    = 1'b1;
          found_d = srch_last_i.hit;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      found_q  <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign found_o     = found_q;

endmodule

// File: rtl/core/fifo_queue_with_search_core.sv
// top level of the fifo queue with membership search
//
//   channel  dir  handshake      payload
//   in_i     in   valid / ready  operation[1:0], value[31:0]
//   out_o    out  valid / ready  status[1:0], data_out[31:0], found
//
// insert, remove and unused codes: result registered and valid in the cycle after the transfer
// search: the key walks the cell chain one cell per cycle; the result is registered when the token leaves the last cell
// one command in flight at a time; the next transfer is taken while the result is taken
// reset empties the queue; entry contents are not cleared
// a stalled result holds the output register and blocks further transfers
module fifo_queue_with_search_core
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH = FqsDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fqs_in_if.sink   in_i,
  fqs_out_if.source out_o
);

  cell_ctrl_t              ctrl;
  q_stat_t                 qstat;
  logic                    occ  [DEPTH];
  logic signed [DataW-1:0] data [DEPTH];
  srch_t                   srch [DEPTH+1];

  fqs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .operation_i  (in_i.operation),
    .value_i      (in_i.value),
    .qstat_i      (qstat),
    .srch_last_i  (srch[DEPTH]),
    .ctrl_o       (ctrl),
    .srch_first_o (srch[0]),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_o     (out_o.status),
    .data_out_o   (out_o.data_out),
    .found_o      (out_o.found)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_occ;
    logic                    next_occ;
    logic signed [DataW-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_occ  = 1'b0;
      assign next_data = '0;
    end else begin : g_body
      assign next_occ  = occ[i+1];
      assign next_data = data[i+1];
    end

    fqs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_occ_i  (prev_occ),
      .next_occ_i  (next_occ),
      .next_data_i (next_data),
      .srch_i      (srch[i]),
      .srch_o      (srch[i+1]),
      .occ_o       (occ[i]),
      .data_o      (data[i])
    );
  end

  assign qstat.head_occ  = occ[0];
  assign qstat.tail_occ  = occ[DEPTH-1];
  assign qstat.head_data = data[0];

endmodule

// File: rtl/core/fqs_checker.sv
// port-level assertions for the fifo queue with search, bound to the top level
module fqs_checker
  import fqs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] data_out_i,
  input logic        found_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (operation_i != OP_SEARCH) |=> out_valid_i)
    else $error("no result after insert or remove transfer");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (operation_i == OP_SEARCH) |=> !in_ready_i && !out_valid_i)
    else $error("block not busy during search");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_EMPTY || status_i == STAT_FULL)
      |-> (data_out_i == '0) && !found_i)
    else $error("payload not zero on empty or full status");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> (status_i == STAT_DONE) && (data_out_i == '0))
    else $error("found set with wrong status or data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_out_i) && $stable(status_i))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .operation_i (in_i.operation),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .data_out_i  (out_o.data_out),
  .found_i     (out_o.found)
);

// File: dv/tb_top.sv
// testbench for the fifo queue with membership search: directed and random commands checked against a queue model
`timescale 1ns / 1ps

module tb_top;
  import fqs_pkg::*;

  localparam int unsigned QDEPTH     = FqsDepth;
  localparam int          NUM_RANDOM = 1630;

  typedef struct {
    op_e                op;
    logic signed [31:0] value;
    bit                 drain;
  } cmd_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] data;
    logic               found;
  } resp_t;

  logic clk_i;
  logic rst_ni;

  fqs_in_if  cmd_if ();
  fqs_out_if rsp_if ();

  fifo_queue_with_search_core #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  cmd_t               pending_cmds[$];
  resp_t              expected_resps[$];
  logic signed [31:0] held_vals[$];
  logic signed [31:0] recent_vals[16];
  int unsigned        recent_wr;
  int                 err_cnt;
  int                 results_seen;
  bit                 cmd_xfer;
  int                 gap_left;
  int                 burst_left;
  int                 stall_phase;
  int                 stall_pct;
  int                 holdoff_left;
  bit                 holdoff_done;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic resp_t queue_step(op_e op, logic signed [31:0] v);
    resp_t r;
    r.status = STAT_DONE;
    r.data   = '0;
    r.found  = 1'b0;
    case (op)
      OP_INSERT: begin
        if (held_vals.size() >= QDEPTH) r.status = STAT_FULL;
        else held_vals.push_back(v);
      end
      OP_REMOVE: begin
        if (held_vals.size() == 0) r.status = STAT_EMPTY;
        else r.data = held_vals.pop_front();
      end
      OP_SEARCH: begin
        foreach (held_vals[i]) if (held_vals[i] == v) r.found = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) v = -v;
      end
      6: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = recent_vals[$urandom_range(0, 15)];
    endcase
    return v;
  endfunction

  task automatic add_cmd(op_e op, logic signed [31:0] v, bit drain);
    cmd_t c;
    c.op    = op;
    c.value = v;
    c.drain = drain;
    if (op == OP_INSERT) begin
      recent_vals[recent_wr] = v;
      recent_wr = (recent_wr + 1) % 16;
    end
    pending_cmds.push_back(c);
  endtask

  // command driver
  always @(negedge clk_i) begin
    cmd_t nxt;
    bit   offer;
    if (rst_ni) begin
      offer    = cmd_if.valid && !cmd_xfer;
      cmd_xfer = 1'b0;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_resps.size() > 0)) begin
          nxt = pending_cmds.pop_front();
          cmd_if.operation <= nxt.op;
          cmd_if.value     <= nxt.value;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 3);
          end
        end
      end
      cmd_if.valid <= offer;
    end
  end

  // result stall pattern
  always @(negedge clk_i) begin
    bit rdy;
    if (rst_ni) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
        rdy = 1'b0;
      end else if (!holdoff_done && results_seen >= 300) begin
        holdoff_done = 1'b1;
        holdoff_left = 400;
        rdy = 1'b0;
      end else begin
        if (stall_phase == 0) begin
          stall_phase = $urandom_range(30, 150);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 80;
          endcase
        end
        stall_phase--;
        rdy = $urandom_range(0, 99) >= stall_pct;
      end
      rsp_if.ready <= rdy;
    end
  end

  // result check, then prediction of the command taken at this edge
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_resps.size() == 0) begin
          $error("result transfer with no command outstanding");
          err_cnt++;
        end else begin
          want = expected_resps.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            err_cnt++;
          end
          if (rsp_if.data_out !== want.data) begin
            $error("data_out: expected %0d, got %0d", want.data, rsp_if.data_out);
            err_cnt++;
          end
          if (rsp_if.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_if.found);
            err_cnt++;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        expected_resps.push_back(queue_step(op_e'(cmd_if.operation), cmd_if.value));
        cmd_xfer = 1'b1;
      end
    end
  end

  initial begin
    int n;
    int seg_len;
    int ins_pct;
    int rem_pct;
    int r;
    op_e op;

    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_INSERT;
    cmd_if.value     = '0;
    rsp_if.ready     = 1'b0;
    err_cnt          = 0;
    results_seen     = 0;
    cmd_xfer         = 1'b0;
    gap_left         = 0;
    burst_left       = 0;
    stall_phase      = 0;
    stall_pct        = 0;
    holdoff_left     = 0;
    holdoff_done     = 1'b0;
    recent_wr        = 0;
    foreach (recent_vals[i]) recent_vals[i] = '0;

    // directed: empty queue, extremes, hits at head and tail, misses, unused code
    add_cmd(OP_REMOVE, 32'sh1234_5678, 1'b0);
    add_cmd(OP_SEARCH, 32'sh0, 1'b0);
    add_cmd(OP_NONE, 32'sh5a5a_a5a5, 1'b0);
    add_cmd(OP_INSERT, 32'sh8000_0000, 1'b0);
    add_cmd(OP_INSERT, 32'sh7fff_ffff, 1'b0);
    add_cmd(OP_INSERT, 32'sh0, 1'b0);
    add_cmd(OP_INSERT, -32'sd1, 1'b0);
    add_cmd(OP_INSERT, 32'sh5555_5555, 1'b0);
    add_cmd(OP_INSERT, 32'shaaaa_aaaa, 1'b0);
    add_cmd(OP_SEARCH, 32'sh7fff_ffff, 1'b0);
    add_cmd(OP_SEARCH, 32'sh8000_0000, 1'b0);
    add_cmd(OP_SEARCH, 32'shaaaa_aaaa, 1'b0);
    add_cmd(OP_SEARCH, 32'sh1, 1'b0);
    for (int i = 0; i < 6; i++) add_cmd(OP_REMOVE, $urandom, 1'b0);
    add_cmd(OP_REMOVE, -32'sd1, 1'b0);
    add_cmd(OP_SEARCH, 32'shaaaa_aaaa, 1'b0);
    add_cmd(OP_NONE, -32'sd1, 1'b0);

    n = 0;
    while (n < NUM_RANDOM) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: begin ins_pct = 60; rem_pct = 15; end
        1: begin ins_pct = 15; rem_pct = 60; end
        default: begin ins_pct = 35; rem_pct = 35; end
      endcase
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + rem_pct) op = OP_REMOVE;
        else if (r < 96) op = OP_SEARCH;
        else op = OP_NONE;
        add_cmd(op, pick_value(), k == 0 && (n == 0 || $urandom_range(0, 7) == 0));
        n++;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (expected_resps.size() != 0) @(posedge clk_i);
    repeat (4 * QDEPTH + 8) @(posedge clk_i);

    if (err_cnt == 0 && expected_resps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fqs_pkg.sv
rtl/core/fqs_in_if.sv
rtl/core/fqs_out_if.sv
rtl/core/fqs_cell.sv
rtl/core/fqs_ctrl.sv
rtl/core/fifo_queue_with_search_core.sv
rtl/core/fqs_checker.sv
dv/tb_top.sv
